FILE: rtl/core/abc_pkg.sv
// Shared types and constants for the alpha border classifier.
`timescale 1ns / 1ps

package abc_pkg;

    // Default size limits for the scan counters.
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Width of the size registers on the configuration port.
    localparam int CFG_SIZE_W = 13;

    // Configuration register indexes (byte address / 4).
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_HAS_ALPHA    = 2'd2;

    // Bit positions in the flag word.
    localparam int FLAG_TOP      = 0;
    localparam int FLAG_BOTTOM   = 1;
    localparam int FLAG_LEFT     = 2;
    localparam int FLAG_RIGHT    = 3;
    localparam int FLAG_INTERNAL = 4;

    // All edge flags set, internal gap flag clear.
    localparam logic [4:0] FLAGS_AT_START = 5'b01111;

    // Mode of the row and frame gap detectors.
    typedef enum logic [1:0] {
        MODE_START   = 2'd0,
        MODE_PADDING = 2'd1,
        MODE_CONTENT = 2'd2
    } t_mode;

    // Position status of the pixel being processed.
    typedef struct packed {
        logic first_col;
        logic last_col;
        logic first_row;
        logic last_row;
    } t_pos;

endpackage

FILE: rtl/core/alpha_border_classifier_core.sv
// Top level of the alpha border classifier: config registers, pixel stage and result register.
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_alpha_value
//  out     | output    | o_out_valid / i_out_ready  | o_flag_top/bottom/left/right/internal
//  cfg     | input     | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One pixel word is taken per clock unless a waiting result stalls the last pixel.
// A frame's last pixel passes the input register, then its flags load the result register.
// The result register stalls only the last pixel of the next frame; other
// pixels keep flowing while a result waits. Synchronous reset clears the scan
// state, the handshake state and the configuration (width 1, height 1, alpha on).
`timescale 1ns / 1ps

module alpha_border_classifier_core #(
    parameter int MAX_WIDTH  = abc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = abc_pkg::DEF_MAX_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Pixel input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_alpha_value,
    // Result output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_flag_top,
    output logic        o_flag_bottom,
    output logic        o_flag_left,
    output logic        o_flag_right,
    output logic        o_flag_internal,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import abc_pkg::*;

    logic [CFG_SIZE_W-1:0] r_image_width, r_image_height;
    logic                  r_has_alpha;
    logic                  cfg_wr;
    logic [1:0]            cfg_idx;

    logic        r_in_valid;
    logic [7:0]  r_in_alpha;
    logic        proc, transparent, frame_end;
    t_pos        pos;

    logic        r_row_clear, n_row_clear;
    logic        row_gap, frame_gap;
    logic [4:0]  r_flags, n_flags, step_flags;

    logic        r_out_valid;
    logic [4:0]  r_out_flags;

    // Configuration registers.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= CFG_SIZE_W'(1);
            r_image_height <= CFG_SIZE_W'(1);
            r_has_alpha    <= 1'b1;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[CFG_SIZE_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[CFG_SIZE_W-1:0];
                REG_HAS_ALPHA:    r_has_alpha    <= pwdata[0];
                default:          ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (cfg_idx)
            REG_IMAGE_WIDTH:  prdata = {{(32 - CFG_SIZE_W){1'b0}}, r_image_width};
            REG_IMAGE_HEIGHT: prdata = {{(32 - CFG_SIZE_W){1'b0}}, r_image_height};
            REG_HAS_ALPHA:    prdata = {31'd0, r_has_alpha};
            default:          prdata = 32'd0;
        endcase
    end

    // Pixel stage: processes whenever its result, if any, has room.
    assign frame_end   = pos.last_col && pos.last_row;
    assign proc        = r_in_valid && (!frame_end || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || proc;
    assign transparent = (r_in_alpha == 8'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_alpha <= i_alpha_value;
        end
    end

    abc_scan_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan_pos (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (proc),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_pos          (pos)
    );

    // Row is fully transparent so far (r_row_clear), including this pixel (n_row_clear).
    assign n_row_clear = r_row_clear && transparent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_clear <= 1'b1;
        end else if (proc) begin
            r_row_clear <= pos.last_col ? 1'b1 : n_row_clear;
        end
    end

    // Gap detector along the row, one pixel per step.
    abc_mode_fsm u_row_fsm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (proc),
        .i_clear       (proc && pos.last_col),
        .i_transparent (transparent),
        .o_gap         (row_gap)
    );

    // Gap detector down the frame, one row per step.
    abc_mode_fsm u_frame_fsm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (proc && pos.last_col),
        .i_clear       (proc && frame_end),
        .i_transparent (n_row_clear),
        .o_gap         (frame_gap)
    );

    // Flag update for this pixel.
    always_comb begin
        step_flags = r_flags;
        if (!transparent) begin
            if (pos.first_col) step_flags[FLAG_LEFT]   = 1'b0;
            if (pos.last_col)  step_flags[FLAG_RIGHT]  = 1'b0;
            if (pos.first_row) step_flags[FLAG_TOP]    = 1'b0;
            if (pos.last_row)  step_flags[FLAG_BOTTOM] = 1'b0;
        end
        if (pos.last_col && row_gap) begin
            step_flags[FLAG_INTERNAL] = 1'b1;
        end
        if (frame_end && frame_gap) begin
            step_flags[FLAG_INTERNAL] = 1'b1;
        end
        n_flags = frame_end ? FLAGS_AT_START : step_flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= FLAGS_AT_START;
        end else if (proc) begin
            r_flags <= n_flags;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && frame_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && frame_end) begin
            r_out_flags <= r_has_alpha ? step_flags : 5'd0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_flag_top      = r_out_flags[FLAG_TOP];
    assign o_flag_bottom   = r_out_flags[FLAG_BOTTOM];
    assign o_flag_left     = r_out_flags[FLAG_LEFT];
    assign o_flag_right    = r_out_flags[FLAG_RIGHT];
    assign o_flag_internal = r_out_flags[FLAG_INTERNAL];

    // A frame end always leaves a result waiting.
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && frame_end |=> o_out_valid)
        else $error("frame end did not load a result");

    // The scan state returns to its start values after a frame.
    a_flags_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && frame_end |=> r_flags == FLAGS_AT_START && r_row_clear)
        else $error("scan state not cleared after frame");

    // A last pixel never overwrites a result that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready && frame_end |-> !proc)
        else $error("result overwritten while stalled");

endmodule

FILE: rtl/core/abc_scan_pos.sv
// Column and row counters of the raster scan with edge detection.
`timescale 1ns / 1ps

module abc_scan_pos #(
    parameter int MAX_WIDTH  = abc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = abc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic [abc_pkg::CFG_SIZE_W-1:0]  i_image_width,
    input  logic [abc_pkg::CFG_SIZE_W-1:0]  i_image_height,
    output abc_pkg::t_pos                   o_pos
);
    import abc_pkg::*;

    localparam int CW  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CMW = (CW + 1 > CFG_SIZE_W) ? CW + 1 : CFG_SIZE_W;
    localparam int CMH = (RW + 1 > CFG_SIZE_W) ? RW + 1 : CFG_SIZE_W;

    logic [CW-1:0]  r_col, n_col;
    logic [RW-1:0]  r_row, n_row;
    logic [CMW-1:0] w_eff, w_cfg;
    logic [CMH-1:0] h_eff, h_cfg;

    // Clamp the configured size into 1..MAX.
    always_comb begin
        w_cfg = CMW'(i_image_width);
        h_cfg = CMH'(i_image_height);
        if (w_cfg == '0) begin
            w_eff = CMW'(1);
        end else if (w_cfg > CMW'(MAX_WIDTH)) begin
            w_eff = CMW'(MAX_WIDTH);
        end else begin
            w_eff = w_cfg;
        end
        if (h_cfg == '0) begin
            h_eff = CMH'(1);
        end else if (h_cfg > CMH'(MAX_HEIGHT)) begin
            h_eff = CMH'(MAX_HEIGHT);
        end else begin
            h_eff = h_cfg;
        end
    end

    // Edge status; position + 1 >= size means the last column or row was reached or passed.
    always_comb begin
        o_pos.first_col = (r_col == '0);
        o_pos.first_row = (r_row == '0);
        o_pos.last_col  = (CMW'(r_col) + CMW'(1)) >= w_eff;
        o_pos.last_row  = (CMH'(r_row) + CMH'(1)) >= h_eff;
    end

    // Next position.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_step) begin
            if (o_pos.last_col) begin
                n_col = '0;
                n_row = o_pos.last_row ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // The column wraps to zero after the last column of a row.
    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_pos.last_col |=> r_col == '0)
        else $error("column did not wrap at row end");

    // The row counter only moves at the end of a row.
    a_row_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !o_pos.last_col |=> r_row == $past(r_row))
        else $error("row moved inside a row");

endmodule

FILE: rtl/core/abc_mode_fsm.sv
// Gap detector: start/padding/content mode machine with a saturating transition count.
`timescale 1ns / 1ps

module abc_mode_fsm (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_advance,
    input  logic i_clear,
    input  logic i_transparent,
    output logic o_gap
);
    import abc_pkg::*;

    t_mode       r_mode, n_mode, adv_mode;
    logic [1:0]  r_count, n_count, adv_count;

    // Advance by one element and test the gap rule on the advanced state.
    always_comb begin
        adv_mode  = r_mode;
        adv_count = r_count;
        case (r_mode)
            MODE_CONTENT: begin
                if (i_transparent) begin
                    adv_mode = MODE_PADDING;
                    if (r_count != 2'd2) begin
                        adv_count = r_count + 2'd1;
                    end
                end
            end
            MODE_PADDING: begin
                if (!i_transparent) begin
                    adv_mode = MODE_CONTENT;
                end
            end
            default: begin
                adv_mode = i_transparent ? MODE_PADDING : MODE_CONTENT;
            end
        endcase

        case (adv_mode)
            MODE_PADDING: o_gap = (adv_count == 2'd2);
            MODE_CONTENT: o_gap = (adv_count != 2'd0);
            default:      o_gap = 1'b0;
        endcase

        if (i_clear) begin
            n_mode  = MODE_START;
            n_count = 2'd0;
        end else if (i_advance) begin
            n_mode  = adv_mode;
            n_count = adv_count;
        end else begin
            n_mode  = r_mode;
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_START;
            r_count <= 2'd0;
        end else begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

    // The counter saturates at two.
    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("transition count overflowed");

    // No transition can have been counted before the first element.
    a_start_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_START |-> r_count == 2'd0)
        else $error("count set in start mode");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the alpha border classifier: random frames checked against a flag predictor.

module tb_top;
    import abc_pkg::*;

    // Clock, reset and block ports; every input starts at a known value.
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_alpha_value   = 8'd0;
    logic        o_out_valid;
    logic        i_out_ready     = 1'b0;
    logic        o_flag_top;
    logic        o_flag_bottom;
    logic        o_flag_left;
    logic        o_flag_right;
    logic        o_flag_internal;
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [3:0]  paddr           = 4'd0;
    logic [31:0] pwdata          = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Flag predictor and queue of expected flag words.
    class flag_scoreboard;
        logic [12:0] width_reg;
        logic [12:0] height_reg;
        logic        alpha_reg;
        int unsigned col_pos;
        int unsigned row_pos;
        t_mode       row_mode;
        t_mode       frame_mode;
        bit          row_blank;
        logic [1:0]  row_gaps;
        logic [1:0]  frame_gaps;
        logic [4:0]  flags;
        logic [4:0]  expected_flags[$];
        int          error_count;

        function new();
            error_count = 0;
            width_reg   = 13'd1;
            height_reg  = 13'd1;
            alpha_reg   = 1'b1;
            restart_scan();
        endfunction

        function void restart_scan();
            col_pos    = 0;
            row_pos    = 0;
            row_mode   = MODE_START;
            frame_mode = MODE_START;
            row_blank  = 1'b1;
            row_gaps   = 2'd0;
            frame_gaps = 2'd0;
            flags      = FLAGS_AT_START;
        endfunction

        task report(string msg);
            $display("tb_top: mismatch: %s", msg);
            error_count++;
        endtask

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_IMAGE_WIDTH:  width_reg  = value[12:0];
                REG_IMAGE_HEIGHT: height_reg = value[12:0];
                REG_HAS_ALPHA:    alpha_reg  = value[0];
                default: ;
            endcase
        endfunction

        // Zero acts as one, and anything past the limit acts as the limit.
        function int unsigned clamp_size(logic [12:0] v, int unsigned lim);
            if (v == 13'd0)
                return 1;
            if (v > lim)
                return lim;
            return v;
        endfunction

        function int unsigned eff_width();
            return clamp_size(width_reg, DEF_MAX_WIDTH);
        endfunction

        function int unsigned eff_height();
            return clamp_size(height_reg, DEF_MAX_HEIGHT);
        endfunction

        function int unsigned pending();
            return expected_flags.size();
        endfunction

        // One step of a gap detector; the transition count saturates at two.
        function void step_mode(inout t_mode m, inout logic [1:0] n, input bit clear_px);
            case (m)
                MODE_CONTENT: begin
                    if (clear_px) begin
                        m = MODE_PADDING;
                        if (n < 2'd2)
                            n = n + 2'd1;
                    end
                end
                MODE_PADDING: begin
                    if (!clear_px)
                        m = MODE_CONTENT;
                end
                default: m = clear_px ? MODE_PADDING : MODE_CONTENT;
            endcase
        endfunction

        function bit gap_seen(t_mode m, logic [1:0] n);
            if (m == MODE_PADDING)
                return n >= 2'd2;
            if (m == MODE_CONTENT)
                return n >= 2'd1;
            return 1'b0;
        endfunction

        // Update the scan state for one accepted pixel word.
        function void note_pixel(logic [7:0] a);
            int unsigned w;
            int unsigned h;
            bit          clear_px;
            bit          last_col;
            bit          last_row;
            w        = eff_width();
            h        = eff_height();
            clear_px = (a == 8'd0);
            last_col = (col_pos >= w - 1);
            last_row = (row_pos >= h - 1);
            if (!clear_px) begin
                if (col_pos == 0)
                    flags[FLAG_LEFT] = 1'b0;
                if (last_col)
                    flags[FLAG_RIGHT] = 1'b0;
                if (row_pos == 0)
                    flags[FLAG_TOP] = 1'b0;
                if (last_row)
                    flags[FLAG_BOTTOM] = 1'b0;
                row_blank = 1'b0;
            end
            step_mode(row_mode, row_gaps, clear_px);
            if (!last_col) begin
                col_pos++;
                return;
            end
            // End of row: feed the row into the frame detector.
            step_mode(frame_mode, frame_gaps, row_blank);
            if (gap_seen(row_mode, row_gaps))
                flags[FLAG_INTERNAL] = 1'b1;
            row_mode  = MODE_START;
            row_gaps  = 2'd0;
            row_blank = 1'b1;
            col_pos   = 0;
            if (!last_row) begin
                row_pos++;
                return;
            end
            if (gap_seen(frame_mode, frame_gaps))
                flags[FLAG_INTERNAL] = 1'b1;
            expected_flags.push_back(alpha_reg ? flags : 5'd0);
            restart_scan();
        endfunction

        function string field_name(int i);
            case (i)
                FLAG_TOP:    return "flag_top";
                FLAG_BOTTOM: return "flag_bottom";
                FLAG_LEFT:   return "flag_left";
                FLAG_RIGHT:  return "flag_right";
                default:     return "flag_internal";
            endcase
        endfunction

        // Compare one result word with the oldest expected flags.
        task check_flags(logic [4:0] got);
            logic [4:0] want;
            if (expected_flags.size() == 0) begin
                report($sformatf("result with nothing expected, flags %b", got));
                return;
            end
            want = expected_flags.pop_front();
            for (int i = 0; i < 5; i++) begin
                if (got[i] !== want[i])
                    report($sformatf("%s got %b expected %b", field_name(i), got[i],
                                     want[i]));
            end
        endtask
    endclass

    flag_scoreboard sb;
    bit             quiet_tail  = 1'b0;
    int unsigned    items_sent  = 0;
    int unsigned    ready_run   = 0;
    int unsigned    ready_stall = 0;

    alpha_border_classifier_core u_top (.*);

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Result side: random stall bursts, none in the tail.
    always @(negedge i_clk) begin
        if (quiet_tail) begin
            i_out_ready <= 1'b1;
        end else if (ready_stall != 0) begin
            i_out_ready <= 1'b0;
            ready_stall <= ready_stall - 1;
        end else if (ready_run != 0) begin
            i_out_ready <= 1'b1;
            ready_run   <= ready_run - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_out_ready <= 1'b0;
            ready_stall <= $urandom_range(0, 16);
        end else begin
            i_out_ready <= 1'b1;
            ready_run   <= $urandom_range(0, 39);
        end
    end

    // Check each accepted result word.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_flags({o_flag_internal, o_flag_right, o_flag_left, o_flag_bottom,
                            o_flag_top});
    end

    // Send one pixel word, sometimes after an idle burst, and wait for acceptance.
    task automatic send_pixel(input logic [7:0] a);
        @(negedge i_clk);
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_alpha_value = a;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_pixel(a);
        items_sent++;
    endtask

    // Stop the stream and let every expected result and the pipeline drain.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Two-phase register write on the configuration port.
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic configure(input logic [31:0] w, input logic [31:0] h, input logic [31:0] a);
        settle();
        cfg_write(REG_IMAGE_WIDTH, w);
        cfg_write(REG_IMAGE_HEIGHT, h);
        cfg_write(REG_HAS_ALPHA, a);
    endtask

    function automatic logic [7:0] opaque_alpha();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] noise_alpha();
        return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom);
    endfunction

    // Mostly tiny sizes, now and then a wider one; zero is included.
    function automatic int unsigned pick_size();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 16)
            return $urandom_range(0, 6);
        if (r < 19)
            return $urandom_range(7, 16);
        return $urandom_range(17, 48);
    endfunction

    // One whole frame: noise, an opaque block with optional holes, blank or solid.
    task automatic send_frame(input int unsigned style);
        int unsigned w;
        int unsigned h;
        int unsigned c0;
        int unsigned c1;
        int unsigned r0;
        int unsigned r1;
        int unsigned hole_r;
        int unsigned hole_c;
        logic [7:0]  a;
        w      = sb.eff_width();
        h      = sb.eff_height();
        c0     = $urandom_range(0, w - 1);
        c1     = $urandom_range(c0, w - 1);
        r0     = $urandom_range(0, h - 1);
        r1     = $urandom_range(r0, h - 1);
        hole_r = $urandom_range(0, 2 * h);
        hole_c = $urandom_range(0, 2 * w);
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                case (style)
                    0: a = noise_alpha();
                    1: a = (c >= c0 && c <= c1 && r >= r0 && r <= r1 && r != hole_r &&
                            c != hole_c) ? opaque_alpha() : 8'd0;
                    2: a = 8'd0;
                    default: a = opaque_alpha();
                endcase
                send_pixel(a);
            end
        end
    endtask

    task automatic random_phase();
        int unsigned r;
        configure(pick_size(), pick_size(), ($urandom_range(0, 9) != 0));
        // Occasionally leave a frame half done so the next size meets it mid-scan.
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, sb.eff_width() * sb.eff_height())) send_pixel(noise_alpha());
        repeat ($urandom_range(1, 4)) begin
            r = $urandom_range(0, 9);
            send_frame(r < 4 ? 0 : r < 8 ? 1 : r == 8 ? 2 : 3);
        end
    endtask

    // Main sequence.
    initial begin
        int unsigned tail_end;
        sb = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset size is one pixel, so every word closes a frame.
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd1);
        send_pixel(8'd128);

        // A row with one gap that ends in padding; upper data bits are dropped.
        configure(32'h0001_2005, 32'd1, 32'd1);
        send_pixel(8'd200);
        send_pixel(8'd0);
        send_pixel(8'd7);
        send_pixel(8'd0);
        send_pixel(8'd0);

        // A column with a gap that ends in content.
        configure(32'd1, 32'd3, 32'd1);
        send_pixel(8'd9);
        send_pixel(8'd0);
        send_pixel(8'd64);

        // Zero sizes behave as one.
        configure(32'd0, 32'd0, 32'd1);
        send_pixel(8'd85);

        // With the alpha channel off every flag reads zero.
        configure(32'd3, 32'd2, 32'hFFFF_FFFE);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd17);
        send_pixel(8'd0);
        send_pixel(8'd0);

        // The width shrinks in the middle of a row.
        configure(32'd4, 32'd1, 32'd1);
        send_pixel(8'd0);
        send_pixel(8'd33);
        settle();
        cfg_write(REG_IMAGE_WIDTH, 32'd2);
        send_pixel(8'd0);

        // Random small frames.
        while (items_sent < 850)
            random_phase();

        // Sizes past the limit keep the scan open; a shrink then closes each frame.
        configure(32'd8191, 32'd0, 32'd1);
        repeat (300) send_pixel(opaque_alpha());
        settle();
        cfg_write(REG_IMAGE_WIDTH, 32'd2);
        send_pixel(8'd0);
        configure(32'd1, 32'd8191, 32'd1);
        repeat (300) send_pixel(noise_alpha());
        settle();
        cfg_write(REG_IMAGE_HEIGHT, 32'd2);
        send_pixel(8'd0);

        // Tail without idling on either side.
        quiet_tail = 1'b1;
        tail_end   = items_sent + 350;
        while (items_sent < tail_end)
            random_phase();

        settle();
        repeat (8) @(posedge i_clk);
        if (sb.error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Watchdog.
    initial begin
        #4_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
